// ----- hw/rtl/dica_pkg.sv -----
// ----------------------------------------------------------------------------
// Dilated im2col address generator: shared definitions
// Field widths, limits, register indexes, controller states and the command
// and status bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package dica_pkg;

  // Geometry limits
  localparam int unsigned MAX_CHANNELS = 1024;
  localparam int unsigned MAX_DIM      = 256;
  localparam int unsigned MAX_KSIZE    = 15;
  localparam int unsigned MAX_DILATION = 16;

  // Configuration field widths
  localparam int unsigned NC_W   = 11;
  localparam int unsigned DIM_W  = 9;
  localparam int unsigned KS_W   = 4;
  localparam int unsigned ST_W   = 4;
  localparam int unsigned PAD_W  = 4;
  localparam int unsigned DIL_W  = 5;
  localparam int unsigned ADDR_W = 32;

  // Result field widths
  localparam int unsigned CROW_W = 18;
  localparam int unsigned CPOS_W = 16;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Counter widths
  localparam int unsigned CH_CNT_W  = $clog2(MAX_CHANNELS);
  localparam int unsigned K_CNT_W   = KS_W;
  localparam int unsigned OUT_CNT_W = $clog2(MAX_DIM);
  // Output extent, up to MAX_DIM inclusive
  localparam int unsigned OUT_LIM_W = OUT_CNT_W + 1;

  // Padded span and dilated extent, and the divider that works on them
  localparam int unsigned SPAN_W    = DIM_W + 1;
  localparam int unsigned DIV_CNT_W = $clog2(SPAN_W + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHANNEL_COUNT = 3'd0,
    REG_IMAGE_HEIGHT  = 3'd1,
    REG_IMAGE_WIDTH   = 3'd2,
    REG_KERNEL_SIZE   = 3'd3,
    REG_STRIDE_STEP   = 3'd4,
    REG_PAD_AMOUNT    = 3'd5,
    REG_DILATION_RATE = 3'd6,
    REG_IMAGE_BASE    = 3'd7
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'd0,
    ST_PREP   = 3'd1,
    ST_DIV    = 3'd2,
    ST_LATCH  = 3'd3,
    ST_MUL    = 3'd4,
    ST_SUM    = 3'd5,
    ST_SCALE  = 3'd6,
    ST_FINISH = 3'd7
  } ctrl_state_e;

  typedef struct packed {
    logic [NC_W-1:0]   channel_count;
    logic [DIM_W-1:0]  image_height;
    logic [DIM_W-1:0]  image_width;
    logic [KS_W-1:0]   kernel_size;
    logic [ST_W-1:0]   stride_step;
    logic [PAD_W-1:0]  pad_amount;
    logic [DIL_W-1:0]  dilation_rate;
    logic [ADDR_W-1:0] image_base;
  } cfg_t;

  typedef struct packed {
    logic cfg_load;   // capture clamped geometry
    logic div_init;   // form extents and start the output-size divide
    logic div_step;   // one quotient bit
    logic div_latch;  // store output height and width
    logic take;       // item accepted, apply restart
    logic mul;        // products of the counters
    logic sum;        // tap position, padding test, row and position sums
    logic scale;      // row index times image width
    logic result;     // load result register, advance counters
  } dica_cmd_t;

  typedef struct packed {
    logic div_last;   // final quotient bit in progress
  } dica_stat_t;

endpackage

// ----- hw/rtl/dica_in_if.sv -----
// ----------------------------------------------------------------------------
// Dilated im2col address generator: request channel
// Valid/ready channel carrying the restart flag of one request.
// ----------------------------------------------------------------------------
interface dica_in_if;

  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);

endinterface

// ----- hw/rtl/dica_out_if.sv -----
// ----------------------------------------------------------------------------
// Dilated im2col address generator: result channel
// Valid/ready channel carrying one column-matrix element.
// ----------------------------------------------------------------------------
interface dica_out_if import dica_pkg::*; ();

  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] image_address;
  logic              is_padding;
  logic [CROW_W-1:0] column_row;
  logic [CPOS_W-1:0] column_position;
  logic              last_element;
  logic              geometry_error;

  modport source (
    output valid, output image_address, output is_padding, output column_row,
    output column_position, output last_element, output geometry_error,
    input  ready
  );
  modport sink (
    input  valid, input image_address, input is_padding, input column_row,
    input  column_position, input last_element, input geometry_error,
    output ready
  );

endinterface

// ----- hw/rtl/dica_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// Dilated im2col address generator: configuration registers
// Write-only register file; each register keeps the low bits of the data.
// ----------------------------------------------------------------------------
module dica_cfg_regs import dica_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q;
  cfg_t cfg_d;

  // Decode the write
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_CHANNEL_COUNT: cfg_d.channel_count = cfg_wdata_i[NC_W-1:0];
        REG_IMAGE_HEIGHT:  cfg_d.image_height  = cfg_wdata_i[DIM_W-1:0];
        REG_IMAGE_WIDTH:   cfg_d.image_width   = cfg_wdata_i[DIM_W-1:0];
        REG_KERNEL_SIZE:   cfg_d.kernel_size   = cfg_wdata_i[KS_W-1:0];
        REG_STRIDE_STEP:   cfg_d.stride_step   = cfg_wdata_i[ST_W-1:0];
        REG_PAD_AMOUNT:    cfg_d.pad_amount    = cfg_wdata_i[PAD_W-1:0];
        REG_DILATION_RATE: cfg_d.dilation_rate = cfg_wdata_i[DIL_W-1:0];
        REG_IMAGE_BASE:    cfg_d.image_base    = cfg_wdata_i[ADDR_W-1:0];
      endcase
    end
  end

  // Hold the registers; reset to the unit geometry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.channel_count <= NC_W'(1);
      cfg_q.image_height  <= DIM_W'(1);
      cfg_q.image_width   <= DIM_W'(1);
      cfg_q.kernel_size   <= KS_W'(1);
      cfg_q.stride_step   <= ST_W'(1);
      cfg_q.pad_amount    <= '0;
      cfg_q.dilation_rate <= DIL_W'(1);
      cfg_q.image_base    <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- hw/rtl/dica_ctrl.sv -----
// ----------------------------------------------------------------------------
// Dilated im2col address generator: controller
// Sequences geometry setup after a register write and the stages of one
// element, and owns the request ready and the result valid.
// ----------------------------------------------------------------------------
module dica_ctrl import dica_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dica_stat_t stat_i,
  output dica_cmd_t  cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        dirty_q, dirty_d;
  logic        out_valid_q, out_valid_d;
  logic        slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (dirty_q) begin
          state_d = ST_PREP;
        end else if (in_valid_i) begin
          state_d = ST_MUL;
        end
      end
      ST_PREP:  state_d = ST_DIV;
      ST_DIV: begin
        if (stat_i.div_last) begin
          state_d = ST_LATCH;
        end
      end
      ST_LATCH: state_d = ST_IDLE;
      ST_MUL:   state_d = ST_SUM;
      ST_SUM:   state_d = ST_SCALE;
      ST_SCALE: state_d = ST_FINISH;
      ST_FINISH: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
    endcase
  end

  // Commands and handshake
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (dirty_q) begin
          cmd_o.cfg_load = 1'b1;
        end else begin
          in_ready_o = 1'b1;
          cmd_o.take = in_valid_i;
        end
      end
      ST_PREP:   cmd_o.div_init  = 1'b1;
      ST_DIV:    cmd_o.div_step  = 1'b1;
      ST_LATCH:  cmd_o.div_latch = 1'b1;
      ST_MUL:    cmd_o.mul       = 1'b1;
      ST_SUM:    cmd_o.sum       = 1'b1;
      ST_SCALE:  cmd_o.scale     = 1'b1;
      ST_FINISH: cmd_o.result    = slot_free;
    endcase
  end

  // Mark geometry stale on a write; a write beats the setup that clears it
  always_comb begin
    dirty_d = dirty_q;
    if (cfg_we_i) begin
      dirty_d = 1'b1;
    end else if (cmd_o.cfg_load) begin
      dirty_d = 1'b0;
    end
  end

  // Result valid: set on load, drop on transfer
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.result) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      dirty_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      dirty_q     <= dirty_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // A register write is never lost
  a_write_marks_dirty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> dirty_q)
    else $error("register write did not mark geometry stale");

  // Work on an element only starts from idle with current geometry
  a_start_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MUL |-> $past(state_q) == ST_IDLE && !$past(dirty_q))
    else $error("element started on stale geometry");

  // A loaded result is offered next cycle
  a_result_offered : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.result |=> out_valid_q)
    else $error("loaded result not offered");

  // A pending result is never overwritten
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |-> !cmd_o.result)
    else $error("result register overwritten while pending");

endmodule

// ----- hw/rtl/dica_datapath.sv -----
// ----------------------------------------------------------------------------
// Dilated im2col address generator: datapath
// Clamped geometry, output-size divider, position counters and the three
// arithmetic stages that turn the counters into one column-matrix element.
// ----------------------------------------------------------------------------
module dica_datapath import dica_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  dica_cmd_t         cmd_i,
  input  logic              restart_i,
  output dica_stat_t        stat_o,
  output logic [ADDR_W-1:0] image_address_o,
  output logic              is_padding_o,
  output logic [CROW_W-1:0] column_row_o,
  output logic [CPOS_W-1:0] column_position_o,
  output logic              last_element_o,
  output logic              geometry_error_o
);

  localparam int unsigned KPROD_W = DIL_W + KS_W;
  localparam int unsigned KK_W    = 2 * KS_W;
  localparam int unsigned ORS_W   = OUT_CNT_W + ST_W;
  localparam int unsigned KRD_W   = K_CNT_W + DIL_W;
  localparam int unsigned POS_W   = ORS_W + 1;
  localparam int unsigned CHH_W   = CH_CNT_W + DIM_W;
  localparam int unsigned CHKK_W  = CH_CNT_W + KK_W;
  localparam int unsigned KRK_W   = K_CNT_W + KS_W;
  localparam int unsigned ORW_W   = OUT_CNT_W + OUT_LIM_W;
  localparam int unsigned IDX_W   = CHH_W + DIM_W;

  // ---------------- clamped geometry ----------------
  logic [NC_W-1:0]      nc_c, eff_nc_q;
  logic [DIM_W-1:0]     h_c, w_c, eff_h_q, eff_w_q;
  logic [KS_W-1:0]      k_c, eff_k_q;
  logic [ST_W-1:0]      s_c, eff_s_q;
  logic [DIL_W-1:0]     d_c, eff_d_q;
  logic [PAD_W-1:0]     eff_p_q;
  logic [ADDR_W-1:0]    base_q;

  always_comb begin
    nc_c = cfg_i.channel_count;
    if (cfg_i.channel_count == '0) begin
      nc_c = NC_W'(1);
    end else if (cfg_i.channel_count > NC_W'(MAX_CHANNELS)) begin
      nc_c = NC_W'(MAX_CHANNELS);
    end
    h_c = cfg_i.image_height;
    if (cfg_i.image_height == '0) begin
      h_c = DIM_W'(1);
    end else if (cfg_i.image_height > DIM_W'(MAX_DIM)) begin
      h_c = DIM_W'(MAX_DIM);
    end
    w_c = cfg_i.image_width;
    if (cfg_i.image_width == '0) begin
      w_c = DIM_W'(1);
    end else if (cfg_i.image_width > DIM_W'(MAX_DIM)) begin
      w_c = DIM_W'(MAX_DIM);
    end
    k_c = cfg_i.kernel_size;
    if (cfg_i.kernel_size == '0) begin
      k_c = KS_W'(1);
    end else if (cfg_i.kernel_size > KS_W'(MAX_KSIZE)) begin
      k_c = KS_W'(MAX_KSIZE);
    end
    s_c = (cfg_i.stride_step == '0) ? ST_W'(1) : cfg_i.stride_step;
    d_c = cfg_i.dilation_rate;
    if (cfg_i.dilation_rate == '0) begin
      d_c = DIL_W'(1);
    end else if (cfg_i.dilation_rate > DIL_W'(MAX_DILATION)) begin
      d_c = DIL_W'(MAX_DILATION);
    end
  end

  // Capture geometry at setup
  always_ff @(posedge clk_i) begin
    if (cmd_i.cfg_load) begin
      eff_nc_q <= nc_c;
      eff_h_q  <= h_c;
      eff_w_q  <= w_c;
      eff_k_q  <= k_c;
      eff_s_q  <= s_c;
      eff_d_q  <= d_c;
      eff_p_q  <= cfg_i.pad_amount;
      base_q   <= cfg_i.image_base;
    end
  end

  // ---------------- extents and output-size divider ----------------
  logic [KPROD_W-1:0]   kprod;
  logic [SPAN_W-1:0]    ext, span_h, span_w;
  logic [KK_W-1:0]      kk_c, kk_q;
  logic                 geo_q;
  logic [SPAN_W-1:0]    quo_h_q, quo_w_q;
  logic [ST_W-1:0]      rem_h_q, rem_w_q;
  logic [DIV_CNT_W-1:0] div_cnt_q;
  logic [ST_W:0]        trial_h, trial_w, diff_h, diff_w;
  logic                 ge_h, ge_w;
  logic [SPAN_W:0]      oh_plus, ow_plus;
  logic [OUT_LIM_W-1:0] oh_q, ow_q;

  assign kprod  = eff_d_q * (eff_k_q - KS_W'(1));
  assign ext    = SPAN_W'(kprod) + SPAN_W'(1);
  assign span_h = SPAN_W'(eff_h_q) + SPAN_W'({eff_p_q, 1'b0});
  assign span_w = SPAN_W'(eff_w_q) + SPAN_W'({eff_p_q, 1'b0});
  assign kk_c   = eff_k_q * eff_k_q;

  // Restoring divide: quotient bits shift in as numerator bits shift out
  assign trial_h = {rem_h_q, quo_h_q[SPAN_W-1]};
  assign trial_w = {rem_w_q, quo_w_q[SPAN_W-1]};
  assign diff_h  = trial_h - {1'b0, eff_s_q};
  assign diff_w  = trial_w - {1'b0, eff_s_q};
  assign ge_h    = trial_h >= {1'b0, eff_s_q};
  assign ge_w    = trial_w >= {1'b0, eff_s_q};

  // One extra bit so that a full-range quotient cannot wrap to zero
  assign oh_plus = {1'b0, quo_h_q} + (SPAN_W + 1)'(1);
  assign ow_plus = {1'b0, quo_w_q} + (SPAN_W + 1)'(1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      geo_q   <= (ext > span_h) || (ext > span_w);
      kk_q    <= kk_c;
      quo_h_q <= span_h - ext;
      quo_w_q <= span_w - ext;
      rem_h_q <= '0;
      rem_w_q <= '0;
    end else if (cmd_i.div_step) begin
      quo_h_q <= {quo_h_q[SPAN_W-2:0], ge_h};
      quo_w_q <= {quo_w_q[SPAN_W-2:0], ge_w};
      rem_h_q <= ge_h ? diff_h[ST_W-1:0] : trial_h[ST_W-1:0];
      rem_w_q <= ge_w ? diff_w[ST_W-1:0] : trial_w[ST_W-1:0];
    end
    // Saturate the output extents at the counter range
    if (cmd_i.div_latch) begin
      oh_q <= (oh_plus > (SPAN_W + 1)'(MAX_DIM)) ? OUT_LIM_W'(MAX_DIM)
                                                 : oh_plus[OUT_LIM_W-1:0];
      ow_q <= (ow_plus > (SPAN_W + 1)'(MAX_DIM)) ? OUT_LIM_W'(MAX_DIM)
                                                 : ow_plus[OUT_LIM_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= '0;
    end else if (cmd_i.div_init) begin
      div_cnt_q <= DIV_CNT_W'(SPAN_W);
    end else if (cmd_i.div_step) begin
      div_cnt_q <= div_cnt_q - DIV_CNT_W'(1);
    end
  end

  assign stat_o.div_last = (div_cnt_q == DIV_CNT_W'(1));

  // ---------------- position counters ----------------
  logic [CH_CNT_W-1:0]  ch_q;
  logic [K_CNT_W-1:0]   kr_q, kc_q;
  logic [OUT_CNT_W-1:0] or_q, oc_q;
  logic [CH_CNT_W:0]    ch_inc;
  logic [K_CNT_W:0]     kr_inc, kc_inc;
  logic [OUT_CNT_W:0]   or_inc, oc_inc;
  logic                 wrap_ch, wrap_kr, wrap_kc, wrap_or, wrap_oc;

  assign ch_inc = {1'b0, ch_q} + 1'b1;
  assign kr_inc = {1'b0, kr_q} + 1'b1;
  assign kc_inc = {1'b0, kc_q} + 1'b1;
  assign or_inc = {1'b0, or_q} + 1'b1;
  assign oc_inc = {1'b0, oc_q} + 1'b1;

  assign wrap_ch = ch_inc >= eff_nc_q;
  assign wrap_kr = kr_inc >= {1'b0, eff_k_q};
  assign wrap_kc = kc_inc >= {1'b0, eff_k_q};
  assign wrap_or = or_inc >= oh_q;
  assign wrap_oc = oc_inc >= ow_q;

  // Clear on restart or error; otherwise ripple the carries, column fastest
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ch_q <= '0;
      kr_q <= '0;
      kc_q <= '0;
      or_q <= '0;
      oc_q <= '0;
    end else if ((cmd_i.take && restart_i) || (cmd_i.result && geo_q)) begin
      ch_q <= '0;
      kr_q <= '0;
      kc_q <= '0;
      or_q <= '0;
      oc_q <= '0;
    end else if (cmd_i.result) begin
      oc_q <= wrap_oc ? '0 : oc_inc[OUT_CNT_W-1:0];
      if (wrap_oc) begin
        or_q <= wrap_or ? '0 : or_inc[OUT_CNT_W-1:0];
        if (wrap_or) begin
          kc_q <= wrap_kc ? '0 : kc_inc[K_CNT_W-1:0];
          if (wrap_kc) begin
            kr_q <= wrap_kr ? '0 : kr_inc[K_CNT_W-1:0];
            if (wrap_kr) begin
              ch_q <= wrap_ch ? '0 : ch_inc[CH_CNT_W-1:0];
            end
          end
        end
      end
    end
  end

  // ---------------- stage 1: products ----------------
  logic [ORS_W-1:0]  or_s_q, oc_s_q;
  logic [KRD_W-1:0]  kr_d_q, kc_d_q;
  logic [CHH_W-1:0]  ch_h_q;
  logic [CHKK_W-1:0] ch_kk_q;
  logic [KRK_W-1:0]  kr_k_q;
  logic [ORW_W-1:0]  or_ow_q;
  logic              last_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      or_s_q  <= or_q * eff_s_q;
      oc_s_q  <= oc_q * eff_s_q;
      kr_d_q  <= kr_q * eff_d_q;
      kc_d_q  <= kc_q * eff_d_q;
      ch_h_q  <= ch_q * eff_h_q;
      ch_kk_q <= ch_q * kk_q;
      kr_k_q  <= kr_q * eff_k_q;
      or_ow_q <= or_q * ow_q;
      last_q  <= wrap_ch && wrap_kr && wrap_kc && wrap_or && wrap_oc;
    end
  end

  // ---------------- stage 2: tap position and sums ----------------
  logic [POS_W-1:0]    row_sum, col_sum, row_val, col_val;
  logic                pad_c;
  logic [CHH_W-1:0]    row_idx_q;
  logic [POS_W-1:0]    col_q;
  logic                pad_q;
  logic [CHKK_W:0]     crow_sum;
  logic [ORW_W:0]      cpos_sum;
  logic [CROW_W-1:0]   crow_q;
  logic [CPOS_W-1:0]   cpos_q;

  assign row_sum = POS_W'(or_s_q) + POS_W'(kr_d_q);
  assign col_sum = POS_W'(oc_s_q) + POS_W'(kc_d_q);
  assign row_val = row_sum - POS_W'(eff_p_q);
  assign col_val = col_sum - POS_W'(eff_p_q);
  // Tap is padding when it falls before the border or past the image edge
  assign pad_c   = (row_sum < POS_W'(eff_p_q)) || (col_sum < POS_W'(eff_p_q)) ||
                   (row_val >= POS_W'(eff_h_q)) || (col_val >= POS_W'(eff_w_q));
  assign crow_sum = (CHKK_W + 1)'(ch_kk_q) + (CHKK_W + 1)'(kr_k_q) + (CHKK_W + 1)'(kc_q);
  assign cpos_sum = (ORW_W + 1)'(or_ow_q) + (ORW_W + 1)'(oc_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.sum) begin
      pad_q     <= pad_c;
      row_idx_q <= ch_h_q + CHH_W'(row_val);
      col_q     <= col_val;
      crow_q    <= crow_sum[CROW_W-1:0];
      cpos_q    <= cpos_sum[CPOS_W-1:0];
    end
  end

  // ---------------- stage 3: scale by image width ----------------
  logic [IDX_W-1:0] idx_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.scale) begin
      idx_q <= row_idx_q * eff_w_q;
    end
  end

  // ---------------- result register ----------------
  logic [ADDR_W-1:0] addr_c;

  assign addr_c = base_q + ADDR_W'(idx_q) + ADDR_W'(col_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.result) begin
      if (geo_q) begin
        image_address_o   <= '0;
        is_padding_o      <= 1'b1;
        column_row_o      <= '0;
        column_position_o <= '0;
        last_element_o    <= 1'b1;
        geometry_error_o  <= 1'b1;
      end else begin
        image_address_o   <= pad_q ? '0 : addr_c;
        is_padding_o      <= pad_q;
        column_row_o      <= crow_q;
        column_position_o <= cpos_q;
        last_element_o    <= last_q;
        geometry_error_o  <= 1'b0;
      end
    end
  end

  // Output extents after setup are never zero nor beyond the counter range
  a_extent_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(cmd_i.div_latch) |-> oh_q != '0 && ow_q != '0 &&
      oh_q <= OUT_LIM_W'(MAX_DIM) && ow_q <= OUT_LIM_W'(MAX_DIM))
    else $error("output extent out of range after setup");

endmodule

// ----- hw/rtl/dilated_im2col_address_generator.sv -----
// ----------------------------------------------------------------------------
// Dilated im2col address generator
// Walks the column matrix of a dilated convolution and issues, per element,
// the source pixel address or a padding flag.
// ----------------------------------------------------------------------------
// Usage:
//   in_i    request channel; restart = 1 begins a new pass at the first
//           element, restart = 0 moves on to the next element.
//   out_o   result channel; one element per request: address, padding flag,
//           column-matrix row and position, last-of-pass and geometry error.
//   cfg_*   write-only register port, registers 0..7 in the order channel
//           count, height, width, kernel size, stride, pad, dilation, base.
// A request's element passes through three arithmetic stages (products, sums,
// width scaling) before the result register, and the next request is taken
// only once that element has been loaded into the result register.
// After reset and after every register write the block derives output height
// and width with a bit-serial divider (one bit per cycle over the 10-bit
// padded span); requests wait meanwhile.
// At reset all counters clear and the geometry is 1x1x1, kernel 1, no pad.
// If the receiver stalls, the result register holds its element; one more
// request may be taken and worked up to the result stage, where it waits.
// ----------------------------------------------------------------------------
module dilated_im2col_address_generator import dica_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  dica_in_if.sink               in_i,
  dica_out_if.source            out_o
);

  cfg_t       cfg;
  dica_cmd_t  cmd;
  dica_stat_t stat;
  logic       in_ready;
  logic       out_valid;

  // Register file
  dica_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Sequencer
  dica_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Arithmetic and counters
  dica_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg),
    .cmd_i             (cmd),
    .restart_i         (in_i.restart),
    .stat_o            (stat),
    .image_address_o   (out_o.image_address),
    .is_padding_o      (out_o.is_padding),
    .column_row_o      (out_o.column_row),
    .column_position_o (out_o.column_position),
    .last_element_o    (out_o.last_element),
    .geometry_error_o  (out_o.geometry_error)
  );

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;

endmodule

// ----- tb/sv/tb_dilated_im2col_address_generator.sv -----
// ----------------------------------------------------------------------------
// Dilated im2col address generator: self-checking testbench
// Walks the block through directed geometries and random passes. A local
// model of the counter walk predicts every column-matrix element and each
// result transfer is compared with the oldest prediction. Both channels idle
// and stall at random, and one long output stall fills the block.
// ----------------------------------------------------------------------------
module tb_dilated_im2col_address_generator;
  import dica_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1750;
  localparam int unsigned STEADY_ITEMS = 200;
  localparam int unsigned SETTLE_CYCLES = 20;

  typedef struct packed {
    logic [ADDR_W-1:0] image_address;
    logic              is_padding;
    logic [CROW_W-1:0] column_row;
    logic [CPOS_W-1:0] column_position;
    logic              last_element;
    logic              geometry_error;
  } column_elem_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we;
  cfg_reg_e              cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  dica_in_if  in_if ();
  dica_out_if out_if ();

  dilated_im2col_address_generator uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  // Model state: registers as written and the five walk counters
  cfg_t                 geom;
  logic [CH_CNT_W-1:0]  chan_pos;
  logic [K_CNT_W-1:0]   krow_pos;
  logic [K_CNT_W-1:0]   kcol_pos;
  logic [OUT_CNT_W-1:0] orow_pos;
  logic [OUT_CNT_W-1:0] ocol_pos;

  column_elem_t awaited_elements[$];

  int unsigned requests_sent = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches = 0;
  int unsigned padding_taps = 0;
  int unsigned pass_ends = 0;
  int unsigned geometry_faults = 0;
  int unsigned geometry_settings = 0;
  int unsigned hold_off_len = 0;
  bit          stall_enable = 1'b1;

  // Clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Hard limit on run time
  initial begin
    #1000000;
    $display("simulation failed");
    $finish;
  end

  function automatic int unsigned clamp_to(input int unsigned v, input int unsigned lo,
                                           input int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void clear_walk();
    chan_pos = '0;
    krow_pos = '0;
    kcol_pos = '0;
    orow_pos = '0;
    ocol_pos = '0;
  endfunction

  // Produce the element at the counters, then advance the walk
  function automatic column_elem_t next_column_element(input logic restart);
    int unsigned nc, h, w, k, s, p, d, ext, span_h, span_w, oh, ow;
    int unsigned ch, kr, kc, ro, co;
    int          row, col;
    logic [31:0] flat;
    column_elem_t e;
    nc = clamp_to(geom.channel_count, 1, MAX_CHANNELS);
    h = clamp_to(geom.image_height, 1, MAX_DIM);
    w = clamp_to(geom.image_width, 1, MAX_DIM);
    k = clamp_to(geom.kernel_size, 1, MAX_KSIZE);
    s = (geom.stride_step == '0) ? 1 : geom.stride_step;
    p = geom.pad_amount;
    d = clamp_to(geom.dilation_rate, 1, MAX_DILATION);
    ext = d * (k - 1) + 1;
    span_h = h + 2 * p;
    span_w = w + 2 * p;
    e = '0;
    if (restart) clear_walk();

    // Dilated kernel does not fit the padded image: flag and clear
    if (ext > span_h || ext > span_w) begin
      e.is_padding = 1'b1;
      e.last_element = 1'b1;
      e.geometry_error = 1'b1;
      clear_walk();
      return e;
    end

    oh = (span_h - ext) / s + 1;
    ow = (span_w - ext) / s + 1;
    if (oh > MAX_DIM) oh = MAX_DIM;
    if (ow > MAX_DIM) ow = MAX_DIM;

    ch = chan_pos;
    kr = krow_pos;
    kc = kcol_pos;
    ro = orow_pos;
    co = ocol_pos;

    row = int'(ro * s + kr * d) - int'(p);
    col = int'(co * s + kc * d) - int'(p);
    e.is_padding = (row < 0 || col < 0 || row >= int'(h) || col >= int'(w));
    if (!e.is_padding)
      e.image_address = geom.image_base + (ch * h + unsigned'(row)) * w + unsigned'(col);
    flat = ch * k * k + kr * k + kc;
    e.column_row = flat[CROW_W-1:0];
    flat = ro * ow + co;
    e.column_position = flat[CPOS_W-1:0];
    e.last_element = (ch + 1 >= nc) && (kr + 1 >= k) && (kc + 1 >= k) &&
                     (ro + 1 >= oh) && (co + 1 >= ow);

    // Ripple the counters, output column fastest; a counter past its limit wraps
    if (co + 1 >= ow) begin
      co = 0;
      if (ro + 1 >= oh) begin
        ro = 0;
        if (kc + 1 >= k) begin
          kc = 0;
          if (kr + 1 >= k) begin
            kr = 0;
            ch = (ch + 1 >= nc) ? 0 : ch + 1;
          end else begin
            kr++;
          end
        end else begin
          kc++;
        end
      end else begin
        ro++;
      end
    end else begin
      co++;
    end
    chan_pos = ch[CH_CNT_W-1:0];
    krow_pos = kr[K_CNT_W-1:0];
    kcol_pos = kc[K_CNT_W-1:0];
    orow_pos = ro[OUT_CNT_W-1:0];
    ocol_pos = co[OUT_CNT_W-1:0];
    return e;
  endfunction

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%08h, actual 0x%08h", $time, field, want, got);
      mismatches++;
    end
  endtask

  // Compare each result transfer, then predict for each request transfer
  always @(posedge clk_i) begin : element_check
    column_elem_t want;
    if (out_if.valid && out_if.ready) begin
      results_seen++;
      if (awaited_elements.size() == 0) begin
        $display("%0t: result with nothing awaited, expected none, actual 0x%08h",
                 $time, out_if.image_address);
        mismatches++;
      end else begin
        want = awaited_elements.pop_front();
        check_field("image_address", want.image_address, out_if.image_address);
        check_field("is_padding", want.is_padding, out_if.is_padding);
        check_field("column_row", want.column_row, out_if.column_row);
        check_field("column_position", want.column_position, out_if.column_position);
        check_field("last_element", want.last_element, out_if.last_element);
        check_field("geometry_error", want.geometry_error, out_if.geometry_error);
        if (want.is_padding) padding_taps++;
        if (want.last_element) pass_ends++;
        if (want.geometry_error) geometry_faults++;
      end
    end
    if (in_if.valid && in_if.ready)
      awaited_elements.push_back(next_column_element(in_if.restart));
  end

  // Receiver: random stalls, or one long hold-off when asked
  initial begin : receiver
    out_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_off_len != 0) begin
        out_if.ready <= 1'b0;
        repeat (hold_off_len) @(posedge clk_i);
        hold_off_len = 0;
      end else if (stall_enable && $urandom_range(0, 5) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
      end else begin
        out_if.ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // Offer one request, at times with a random gap first, and hold until its transfer
  task automatic send_request(input logic restart_flag);
    if (stall_enable && $urandom_range(0, 4) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.restart <= restart_flag;
    do @(posedge clk_i); while (!in_if.ready);
    requests_sent++;
  endtask

  // Drop valid and wait until every accepted request has its result
  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (results_seen != requests_sent) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    @(posedge clk_i);
    case (idx)
      REG_CHANNEL_COUNT: geom.channel_count = data[NC_W-1:0];
      REG_IMAGE_HEIGHT:  geom.image_height  = data[DIM_W-1:0];
      REG_IMAGE_WIDTH:   geom.image_width   = data[DIM_W-1:0];
      REG_KERNEL_SIZE:   geom.kernel_size   = data[KS_W-1:0];
      REG_STRIDE_STEP:   geom.stride_step   = data[ST_W-1:0];
      REG_PAD_AMOUNT:    geom.pad_amount    = data[PAD_W-1:0];
      REG_DILATION_RATE: geom.dilation_rate = data[DIL_W-1:0];
      REG_IMAGE_BASE:    geom.image_base    = data;
      default: ;
    endcase
  endtask

  // Write all eight registers once the block is idle; optional junk above each field but the base
  task automatic program_geometry(input int unsigned nc, input int unsigned h,
                                  input int unsigned w, input int unsigned k,
                                  input int unsigned s, input int unsigned p,
                                  input int unsigned d, input logic [31:0] base,
                                  input bit dirty);
    logic [31:0] noise;
    drain_results();
    noise = dirty ? $urandom() : '0;
    write_reg(REG_CHANNEL_COUNT, (noise << NC_W) | nc);
    write_reg(REG_IMAGE_HEIGHT, (noise << DIM_W) | h);
    write_reg(REG_IMAGE_WIDTH, (noise << DIM_W) | w);
    write_reg(REG_KERNEL_SIZE, (noise << KS_W) | k);
    write_reg(REG_STRIDE_STEP, (noise << ST_W) | s);
    write_reg(REG_PAD_AMOUNT, (noise << PAD_W) | p);
    write_reg(REG_DILATION_RATE, (noise << DIL_W) | d);
    write_reg(REG_IMAGE_BASE, base);
    cfg_we <= 1'b0;
    geometry_settings++;
  endtask

  // Default 1x1 geometry straight out of reset
  task automatic test_reset_state();
    send_request(1'b0);
    send_request(1'b1);
  endtask

  // Short walk, then new registers without a restart so counters stand past limits
  task automatic test_walk_and_reconfig();
    program_geometry(2, 3, 3, 2, 1, 1, 2, 32'h0000_1000, 1'b0);
    send_request(1'b1);
    repeat (3) send_request(1'b0);
    program_geometry(1, 2, 2, 1, 2, 0, 1, 32'h8000_0000, 1'b0);
    repeat (2) send_request(1'b0);
  endtask

  // Largest legal geometry, and an address that wraps past the top
  task automatic test_geometry_extremes();
    program_geometry(MAX_CHANNELS, MAX_DIM, MAX_DIM, MAX_KSIZE, 15, 15, MAX_DILATION,
                     32'hFFFF_FFFF, 1'b0);
    send_request(1'b1);
    repeat (2) send_request(1'b0);
    program_geometry(MAX_CHANNELS, MAX_DIM, MAX_DIM, 1, 1, 0, 1, 32'hFFFF_FFFF, 1'b0);
    send_request(1'b1);
    send_request(1'b0);
  endtask

  // Zero and oversized register values must clamp
  task automatic test_out_of_range_registers();
    program_geometry(0, 0, 0, 0, 0, 0, 0, 32'h0000_0000, 1'b1);
    send_request(1'b1);
    send_request(1'b0);
    program_geometry(2047, 511, 511, 15, 0, 15, 31, 32'h1234_5678, 1'b1);
    send_request(1'b1);
  endtask

  // Output extent beyond the maximum saturates
  task automatic test_output_saturation();
    program_geometry(3, MAX_DIM, MAX_DIM, 1, 1, 15, 1, 32'h0000_0000, 1'b0);
    send_request(1'b1);
    send_request(1'b0);
  endtask

  // Dilated kernel too tall and too wide, then only too wide
  task automatic test_geometry_error();
    program_geometry(1, 4, 4, 3, 1, 0, 2, 32'h0000_0200, 1'b0);
    send_request(1'b1);
    send_request(1'b0);
    program_geometry(1, 16, 2, 3, 1, 0, 1, 32'h0000_0200, 1'b0);
    send_request(1'b0);
  endtask

  // Hold the output off long enough for the block to stall its input
  task automatic test_output_backpressure();
    int i;
    program_geometry(2, 4, 4, 2, 1, 1, 1, 32'h0000_4000, 1'b0);
    hold_off_len = 300;
    for (i = 0; i < 8; i++) send_request(i == 0);
  endtask

  // Mostly tiny geometries walked through whole passes, some wide random settings
  task automatic test_random_passes();
    int unsigned issued, run_len;
    int          i;
    bit          wide;
    issued = 0;
    while (issued < RANDOM_ITEMS) begin
      wide = ($urandom_range(0, 7) == 0);
      if (wide)
        program_geometry($urandom_range(0, 2047), $urandom_range(0, 511),
                         $urandom_range(0, 511), $urandom_range(0, 15),
                         $urandom_range(0, 15), $urandom_range(0, 15),
                         $urandom_range(0, 31), $urandom(), $urandom_range(0, 1));
      else
        program_geometry($urandom_range(1, 2), $urandom_range(1, 6), $urandom_range(1, 6),
                         $urandom_range(1, 3), $urandom_range(1, 3), $urandom_range(0, 2),
                         $urandom_range(1, 2), $urandom(), 1'b0);
      run_len = wide ? $urandom_range(8, 24) : $urandom_range(20, 100);
      // First request usually restarts; otherwise carry on from the old counters
      for (i = 0; i < run_len; i++)
        send_request((i == 0) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 39) == 0));
      issued += run_len;
    end
  endtask

  // Back-to-back transfers with no idling on either side
  task automatic test_steady_stream();
    int i;
    program_geometry(2, 5, 4, 2, 1, 1, 1, $urandom(), 1'b0);
    stall_enable = 1'b0;
    for (i = 0; i < STEADY_ITEMS; i++) send_request(i == 0);
  endtask

  initial begin
    in_if.valid <= 1'b0;
    in_if.restart <= 1'b0;
    cfg_we <= 1'b0;
    cfg_idx <= REG_CHANNEL_COUNT;
    cfg_wdata <= '0;
    geom = '0;
    geom.channel_count = 1;
    geom.image_height = 1;
    geom.image_width = 1;
    geom.kernel_size = 1;
    geom.stride_step = 1;
    geom.dilation_rate = 1;
    clear_walk();

    // Hold reset, then release
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_walk_and_reconfig();
    test_geometry_extremes();
    test_out_of_range_registers();
    test_output_saturation();
    test_geometry_error();
    test_output_backpressure();
    test_random_passes();
    test_steady_stream();

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (awaited_elements.size() != 0) begin
      $display("%0t: %0d elements never arrived", $time, awaited_elements.size());
      mismatches++;
    end

    $display("Checked %0d requests over %0d register settings", requests_sent,
             geometry_settings);
    $display("Saw %0d padding taps, %0d pass ends, %0d geometry errors, %0d mismatches",
             padding_taps, pass_ends, geometry_faults, mismatches);
    if (mismatches == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
